// ===== hw/rtl/bytecode_stack_machine_unit_assert.svh =====
// Assertion macros for the stack machine
`ifndef BYTECODE_STACK_MACHINE_UNIT_ASSERT_SVH
`define BYTECODE_STACK_MACHINE_UNIT_ASSERT_SVH

// Check that a condition implies a consequence on the same edge
`define BSM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence on the next edge
`define BSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/bsm_pkg.sv =====
package bsm_pkg;

  localparam int StackDepth = 32;
  localparam int SymbolEntries = 16;
  localparam int NameBits = 16;
  localparam int SpW = $clog2(StackDepth + 1);
  localparam int SaW = $clog2(StackDepth);
  localparam int ScW = $clog2(SymbolEntries + 1);
  localparam int SiW = (SymbolEntries > 1) ? $clog2(SymbolEntries) : 1;

  localparam logic [3:0] CMD_PUSH  = 4'd0;
  localparam logic [3:0] CMD_POP   = 4'd1;
  localparam logic [3:0] CMD_STORE = 4'd2;
  localparam logic [3:0] CMD_LOAD  = 4'd3;
  localparam logic [3:0] CMD_ADD   = 4'd4;
  localparam logic [3:0] CMD_SUB   = 4'd5;
  localparam logic [3:0] CMD_MUL   = 4'd6;
  localparam logic [3:0] CMD_DIV   = 4'd7;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;
  localparam logic [2:0] ST_DIVZERO = 3'd5;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

endpackage

// ===== hw/rtl/bsm_divider.sv =====
module bsm_divider import bsm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // Restoring divide of |num|<<16 by |den|, one quotient bit per cycle
  logic [47:0] dividend;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [31:0] quot;
  logic [32:0] rem_shift;
  logic [33:0] diff;
  logic [48:0] mag;

  assign rem_shift = {rem[31:0], dividend[47]};
  assign diff = {1'b0, rem_shift} - {2'b0, dvs};
  assign rsp = '{done: done, quot: quot};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd48;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend <= {(req.num[31] ? 32'd0 - req.num : req.num), 16'd0};
      dvs <= req.den[31] ? 32'd0 - req.den : req.den;
      neg <= req.num[31] ^ req.den[31];
      rem <= '0;
    end else if (busy) begin
      if (!diff[33]) begin
        rem <= diff[32:0];
        dividend <= {dividend[46:0], 1'b1};
      end else begin
        rem <= rem_shift;
        dividend <= {dividend[46:0], 1'b0};
      end
    end
  end

  // Apply sign and saturate
  always_comb begin
    mag = neg ? 49'd0 - {1'b0, dividend} : {1'b0, dividend};
    if (!mag[48] && mag[47:31] != 17'd0) quot = 32'h7fffffff;
    else if (mag[48] && mag[47:31] != 17'h1ffff) quot = 32'h80000000;
    else quot = mag[31:0];
  end

endmodule

// ===== hw/rtl/bytecode_stack_machine_unit.sv =====
// Each word passes through S_RD1 and S_RD2 (top and second read), S_EXEC,
// S_WB, S_TOP and S_OUT; load adds S_SRCH (one symbol entry per cycle),
// and mul and div add S_DIV (div waits on the 48-step serial divider).
// One word in flight; the next word is accepted in the cycle after the
// result leaves.
// Reset clears the state machine, stack pointer, symbol count and prod_v only.
module bytecode_stack_machine_unit import bsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  command,
  input  logic signed [31:0] operand_value,
  input  logic [15:0] name_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic signed [31:0] top_value,
  output logic [5:0]  stack_count
);
`include "bytecode_stack_machine_unit_assert.svh"

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD1   = 9'b000000010,
    S_RD2   = 9'b000000100,
    S_SRCH  = 9'b000001000,
    S_EXEC  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_WB    = 9'b001000000,
    S_TOP   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [SpW-1:0] sp;
  logic [ScW-1:0] sc;
  logic [3:0]  cmd;
  logic [31:0] val;
  logic [NameBits-1:0] key;
  logic [31:0] top, sec, res;
  logic [2:0]  st;
  logic [ScW-1:0] idx;

  logic [31:0] stk_mem [StackDepth];
  logic [31:0] stk_rd;
  logic        stk_we;
  logic [SaW-1:0] stk_wa, stk_ra;
  logic [31:0] stk_wd;

  logic [NameBits-1:0] key_mem [SymbolEntries];
  logic [31:0] symv_mem [SymbolEntries];
  logic [NameBits-1:0] key_rd;
  logic [31:0] symv_rd;
  logic        sym_we;
  logic [SiW-1:0] sym_ra;

  logic [63:0] prod;
  logic        prod_v;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [32:0] sum;

  // Memories: registered reads
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
    if (sym_we) begin
      key_mem[sc[SiW-1:0]] <= key;
      symv_mem[sc[SiW-1:0]] <= top;
    end
    key_rd <= key_mem[sym_ra];
    symv_rd <= symv_mem[sym_ra];
  end

  bsm_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign stack_count = 6'(sp);
  assign sym_ra = idx[SiW-1:0];

  // Read address: top, then second; final top readback
  always_comb begin
    stk_ra = sp[SaW-1:0] - SaW'(1);
    if (state == S_RD2) stk_ra = sp[SaW-1:0] - SaW'(2);
  end

  assign dreq = '{start: (state == S_EXEC) && (cmd == CMD_DIV) && st == ST_OK,
                  num: top, den: sec};

  always_ff @(posedge clk) prod <= $signed(top) * $signed(sec);

  always_comb begin
    sum = (cmd == CMD_ADD) ? {top[31], top} + {sec[31], sec}
                           : {top[31], top} - {sec[31], sec};
  end

  always_comb begin
    stk_we = 1'b0;
    stk_wa = sp[SaW-1:0];
    stk_wd = res;
    sym_we = 1'b0;
    if (state == S_WB && st == ST_OK) begin
      case (cmd)
        CMD_PUSH, CMD_LOAD: stk_we = 1'b1;
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
          stk_we = 1'b1;
          stk_wa = sp[SaW-1:0] - SaW'(2);
        end
        CMD_STORE: sym_we = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
      sc <= '0;
      prod_v <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          cmd <= command;
          val <= operand_value;
          key <= name_key[NameBits-1:0];
          st <= ST_OK;
          idx <= '0;
          prod_v <= 1'b0;
          state <= S_RD1;
        end
        S_RD1: state <= S_RD2;
        S_RD2: begin
          if (!prod_v) top <= stk_rd;
          state <= S_RD2;
          // second word arrives next cycle
          if (prod_v) begin
            sec <= stk_rd;
            state <= (cmd == CMD_LOAD) ? S_SRCH : S_EXEC;
          end
          prod_v <= ~prod_v;
        end
        S_SRCH: begin
          // one symbol entry per cycle; data arrives in the cycle after its address
          prod_v <= 1'b0;
          if (idx != '0 && key_rd == key) begin
            res <= symv_rd;
            state <= S_EXEC;
          end else if (idx >= sc) begin
            st <= ST_MISSING;
            state <= S_EXEC;
          end else idx <= idx + ScW'(1);
        end
        S_EXEC: begin
          state <= S_WB;
          case (cmd)
            CMD_PUSH: if (sp >= SpW'(StackDepth)) st <= ST_OVER; else res <= val;
            CMD_POP: if (sp == '0) st <= ST_UNDER;
            CMD_STORE: if (sp == '0) st <= ST_UNDER;
                       else if (sc >= ScW'(SymbolEntries)) st <= ST_FULL;
            CMD_LOAD: if (st == ST_OK && sp >= SpW'(StackDepth)) st <= ST_OVER;
            CMD_ADD, CMD_SUB: if (sp < SpW'(2)) st <= ST_UNDER;
              else if (sum[32] != sum[31]) res <= sum[32] ? 32'h80000000 : 32'h7fffffff;
              else res <= sum[31:0];
            CMD_MUL: if (sp < SpW'(2)) st <= ST_UNDER;
              else begin
                state <= S_DIV;
              end
            CMD_DIV: if (sp < SpW'(2)) st <= ST_UNDER;
              else if (sec == '0) st <= ST_DIVZERO;
              else state <= S_DIV;
            default: ;
          endcase
          if (cmd == CMD_DIV && (sp < SpW'(2) || sec == '0)) state <= S_WB;
        end
        S_DIV: begin
          if (cmd == CMD_MUL) begin
            if (!prod[63] && prod[62:47] != 16'd0) res <= 32'h7fffffff;
            else if (prod[63] && prod[62:47] != 16'hffff) res <= 32'h80000000;
            else res <= prod[47:16];
            state <= S_WB;
          end else if (drsp.done) begin
            res <= drsp.quot;
            state <= S_WB;
          end
        end
        S_WB: begin
          if (st == ST_OK) begin
            case (cmd)
              CMD_PUSH, CMD_LOAD: sp <= sp + SpW'(1);
              CMD_POP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: sp <= sp - SpW'(1);
              CMD_STORE: begin
                sp <= sp - SpW'(1);
                sc <= sc + ScW'(1);
              end
              default: ;
            endcase
          end
          state <= S_TOP;
          prod_v <= 1'b0;
        end
        S_TOP: begin
          // wait for the registered top readback
          prod_v <= ~prod_v;
          if (prod_v) state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_TOP) top_value <= (sp == '0) ? 32'd0 : stk_rd;
    if (state == S_TOP) status <= st;
  end

  `BSM_ASSERT_IMPL(a_sp_range, clk, rst, 1'b1, sp <= SpW'(StackDepth))
  `BSM_ASSERT_IMPL(a_sc_range, clk, rst, 1'b1, sc <= ScW'(SymbolEntries))
  `BSM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import bsm_pkg::*;

  // call and return have no package constant
  localparam logic [3:0] CMD_CALL = 4'd8;
  localparam logic [3:0] CMD_RET  = 4'd9;
  localparam int CycleLimit = 600000;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] top;
    logic [5:0]  count;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] command = '0;
  logic signed [31:0] operand_value = '0;
  logic [15:0] name_key = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic signed [31:0] top_value;
  logic [5:0] stack_count;

  // predictor state
  logic signed [31:0] model_stack [StackDepth];
  int unsigned model_sp;
  logic [15:0] model_keys [SymbolEntries];
  logic signed [31:0] model_vals [SymbolEntries];
  int unsigned model_nsym;

  step_result_t pending_results[$];
  int unsigned errors;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned cycles;
  bit stall_free;

  bytecode_stack_machine_unit u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .operand_value(operand_value), .name_key(name_key),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .top_value(top_value), .stack_count(stack_count)
  );

  always #2 clk = ~clk;

  // saturate a 64-bit value to 32 bits
  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // compute one step of the machine and the word it reports
  function automatic step_result_t execute_command(input logic [3:0] cmd,
                                                   input logic signed [31:0] val,
                                                   input logic [15:0] key);
    step_result_t r;
    logic [2:0] st;
    logic signed [31:0] a, b, res;
    logic signed [63:0] p;
    bit found;
    logic signed [31:0] hit;
    st = ST_OK;
    found = 0;
    hit = '0;
    case (cmd)
      CMD_PUSH: begin
        if (model_sp >= StackDepth) st = ST_OVER;
        else begin
          model_stack[model_sp] = val;
          model_sp++;
        end
      end
      CMD_POP: begin
        if (model_sp == 0) st = ST_UNDER;
        else model_sp--;
      end
      CMD_STORE: begin
        if (model_sp == 0) st = ST_UNDER;
        else if (model_nsym >= SymbolEntries) st = ST_FULL;
        else begin
          model_keys[model_nsym] = key;
          model_vals[model_nsym] = model_stack[model_sp - 1];
          model_nsym++;
          model_sp--;
        end
      end
      CMD_LOAD: begin
        for (int i = 0; i < model_nsym; i++) begin
          if (!found && model_keys[i] == key) begin
            found = 1;
            hit = model_vals[i];
          end
        end
        if (!found) st = ST_MISSING;
        else if (model_sp >= StackDepth) st = ST_OVER;
        else begin
          model_stack[model_sp] = hit;
          model_sp++;
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (model_sp < 2) st = ST_UNDER;
        else begin
          a = model_stack[model_sp - 1];
          b = model_stack[model_sp - 2];
          if (cmd == CMD_DIV && b == 0) st = ST_DIVZERO;
          else begin
            if (cmd == CMD_ADD) res = clamp32(64'(a) + 64'(b));
            else if (cmd == CMD_SUB) res = clamp32(64'(a) - 64'(b));
            else if (cmd == CMD_MUL) begin
              p = 64'(a) * 64'(b);
              res = clamp32(p >>> 16);
            end else begin
              p = 64'(a) <<< 16;
              res = clamp32(p / 64'(b));
            end
            model_stack[model_sp - 2] = res;
            model_sp--;
          end
        end
      end
      default: ;
    endcase
    r.status = st;
    r.top = (model_sp != 0) ? model_stack[model_sp - 1] : '0;
    r.count = model_sp[5:0];
    return r;
  endfunction

  // draw a gap length: mostly zero or short, sometimes long
  function automatic int unsigned gap_len();
    int unsigned roll;
    if (stall_free) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one word and record its expected result
  task automatic send_word(input logic [3:0] cmd, input logic signed [31:0] val,
                           input logic [15:0] key);
    int unsigned gap;
    gap = gap_len();
    // drop valid across a gap; hold it high when words follow back to back
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command <= cmd;
    operand_value <= val;
    name_key <= key;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(execute_command(cmd, val, key));
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // receive side: random back-pressure, always ready when stall_free is set
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (stall_free) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    step_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected word: status=%0d top=%0d count=%0d",
               status, top_value, stack_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          errors++;
        end
        if (top_value !== want.top) begin
          $error("top_value: expected %0d, actual %0d", $signed(want.top), top_value);
          errors++;
        end
        if (stack_count !== want.count) begin
          $error("stack_count: expected %0d, actual %0d", want.count, stack_count);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_key();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 7));
  endfunction

  // extremes, every command, underflow, missing name and divide by zero
  task automatic test_directed();
    send_word(CMD_POP, '0, '0);
    send_word(CMD_STORE, '0, 16'h1);
    send_word(CMD_ADD, '0, '0);
    send_word(CMD_LOAD, '0, 16'hffff);
    send_word(CMD_PUSH, 32'sh7fffffff, '0);
    send_word(CMD_PUSH, 32'sh7fffffff, '0);
    send_word(CMD_ADD, '0, '0);
    send_word(CMD_PUSH, 32'sh80000000, '0);
    send_word(CMD_SUB, '0, '0);
    send_word(CMD_PUSH, 32'sh00018000, '0);
    send_word(CMD_MUL, '0, '0);
    send_word(CMD_PUSH, 32'shffff0001, '0);
    send_word(CMD_MUL, '0, '0);
    send_word(CMD_PUSH, '0, '0);
    send_word(CMD_PUSH, 32'sh00050000, '0);
    send_word(CMD_DIV, '0, '0);
    send_word(CMD_POP, '0, '0);
    send_word(CMD_PUSH, 32'sh00000003, '0);
    send_word(CMD_DIV, '0, '0);
    send_word(CMD_STORE, '0, 16'hffff);
    send_word(CMD_LOAD, '0, 16'hffff);
    send_word(CMD_CALL, 32'sh12345678, 16'h5);
    send_word(CMD_RET, '0, '0);
    send_word(4'hf, 32'shffffffff, 16'hffff);
    send_word(4'ha, '0, '0);
  endtask

  // fill the stack past full, then fill the table past full and load the oldest
  task automatic test_limits();
    for (int i = 0; i < StackDepth + 2; i++) send_word(CMD_PUSH, rand_value(), '0);
    send_word(CMD_LOAD, '0, 16'hffff);
    for (int i = 0; i < SymbolEntries + 2; i++) send_word(CMD_STORE, '0, 16'(i % 3));
    send_word(CMD_LOAD, '0, 16'h0);
    send_word(CMD_LOAD, '0, 16'h2);
    // pause until the machine has answered everything
    wait_drained();
    while (model_sp > 0) send_word(CMD_POP, '0, '0);
  endtask

  // random programs: mostly well-formed expression runs, some noise
  task automatic test_random(input int unsigned count);
    int unsigned n;
    logic [3:0] cmd;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 3) != 0) begin
        // balanced sequence: push operands, reduce, maybe store, then load
        for (int k = $urandom_range(2, 5); k > 0; k--) begin
          send_word(CMD_PUSH, rand_value(), 16'($urandom));
          n++;
        end
        for (int k = $urandom_range(1, 4); k > 0; k--) begin
          send_word(4'($urandom_range(CMD_ADD, CMD_DIV)), rand_value(), 16'($urandom));
          n++;
        end
        if ($urandom_range(0, 1)) begin
          send_word(CMD_STORE, rand_value(), rand_key());
          n++;
        end
        send_word(CMD_LOAD, rand_value(), rand_key());
        n++;
      end else begin
        cmd = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
        send_word(cmd, rand_value(), 16'($urandom));
        n++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    model_sp = 0;
    model_nsym = 0;
    @(posedge clk);
    test_directed();
    test_limits();
    test_random(600);
    stall_free = 1;
    test_random(100);
    stall_free = 0;
    test_random(500);
    wait_drained();
    $display("covered %0d words, %0d results checked, symbols bound: %0d",
             words_sent, words_checked, model_nsym);
    $display("stack and table limits, saturation and divide by zero exercised");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
